### rtl/idxpq_pkg.sv
// ----------------------------------------------------------------------------
// idxpq_pkg - shared types for the indexed min priority queue
// Entry layout, control bundle for the sorted cell chain, codes and ordering.
// ----------------------------------------------------------------------------
package idxpq_pkg;

    localparam int ID_W        = 16;
    localparam int KEY_W       = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY_POP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic [ID_W-1:0]         ident;
        logic signed [KEY_W-1:0] key;
    } t_entry;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic   remove;   // removal pass: matched cell and everything after it shift down
        logic   insert;   // insertion pass: new entry goes in at its sorted place
        logic   is_pop;   // removal targets the head, not an ident match
        t_entry item;     // entry being pushed
    } t_cell_ctrl;

    // true when entry a is served before entry b (key, then ident)
    function automatic logic entry_before(input t_entry a, input t_entry b);
        if (a.key != b.key) begin
            return a.key < b.key;
        end
        return a.ident < b.ident;
    endfunction

endpackage

### rtl/idxpq_cell.sv
// ----------------------------------------------------------------------------
// idxpq_cell - one slot of the sorted entry chain
// Holds one entry; shifts down on removal, shifts up or loads on insertion.
// ----------------------------------------------------------------------------
module idxpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  idxpq_pkg::t_cell_ctrl i_ctrl,
    input  idxpq_pkg::t_entry     i_left,        // entry of the cell before
    input  idxpq_pkg::t_entry     i_right,       // entry of the cell after
    input  logic                  i_left_shift,  // removal point is at or before the cell before
    input  logic                  i_left_lt,     // new entry sorts before the cell before
    output idxpq_pkg::t_entry     o_entry,
    output idxpq_pkg::t_entry     o_next,
    output logic                  o_shift,
    output logic                  o_lt
);
    import idxpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;

    // ident hit, only on push removal pass
    assign w_match = i_ctrl.remove && !i_ctrl.is_pop && r_entry.valid
                     && (r_entry.ident == i_ctrl.item.ident);
    assign o_shift = i_left_shift || w_match;
    assign o_lt    = !r_entry.valid || entry_before(i_ctrl.item, r_entry);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.remove && o_shift) begin
            n_entry = i_right;
        end else if (i_ctrl.insert && o_lt) begin
            n_entry = i_left_lt ? i_left : i_ctrl.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.ident <= n_entry.ident;
        r_entry.key   <= n_entry.key;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

### rtl/indexed_min_priority_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_priority_queue - indexed min priority queue with key update
// Sorted chain of CAPACITY cells; head cell always holds the minimum entry.
// ----------------------------------------------------------------------------
// Each transfer in is a push (insert a new ident, or replace the key of an
// ident already held) or a pop of the minimum. Entries stay sorted by signed
// key, ties broken by smaller ident, across a chain of identical cells, so the
// minimum is always in the head cell. An operation is a removal pass (pop
// takes the head, a push drops any cell holding the same ident and the cells
// behind it close the gap) followed by an insertion pass (cells past the new
// entry's place move up one, the cell at its place loads it). The next item
// is taken at the edge that ends the insertion pass, so no new item is taken
// while one is in flight; the insertion pass waits while a previous result is
// still held stalled at the output. Each item yields one result transfer with
// the minimum ident/key after the operation (zero when empty), the empty flag,
// the count (low 5 bits) and a status: done, push dropped on a full store, or
// pop ignored on an empty store. Reset clears the store.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_operation,
    input  logic [idxpq_pkg::ID_W-1:0]             i_ident,
    input  logic signed [idxpq_pkg::KEY_W-1:0]     i_prio_key,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [idxpq_pkg::ID_W-1:0]             o_min_ident,
    output logic signed [idxpq_pkg::KEY_W-1:0]     o_min_key,
    output logic                                   o_is_empty,
    output logic [idxpq_pkg::COUNT_OUT_W-1:0]      o_entry_count,
    output logic [1:0]                             o_status
);
    import idxpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    // sequencer
    t_state r_state, n_state;
    t_op    r_op;
    t_entry r_item;
    logic   r_hit;        // push found its ident in the removal pass
    logic [CNT_W-1:0] r_count, n_count;

    // result register
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_min_ident;
    logic signed [KEY_W-1:0] r_min_key;
    logic                 r_is_empty;
    logic [CNT_W-1:0]     r_res_count;
    t_status              r_status, n_status;

    logic       w_out_free;
    logic       w_commit;
    logic       w_in_xfer;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    // cell chain wiring
    t_entry w_entry [CAPACITY];
    t_entry w_next  [CAPACITY];
    logic   w_shift [CAPACITY];
    logic   w_lt    [CAPACITY];

    logic [EXT_W-1:0] w_count_ext;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_INSERT) && w_out_free;
    assign o_in_stall = !((r_state == S_IDLE) || w_commit);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_REMOVE;
            S_REMOVE: n_state = S_INSERT;
            S_INSERT: if (w_out_free) n_state = i_in_valid ? S_REMOVE : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // cell control, count and status
    always_comb begin
        w_ctrl.remove = (r_state == S_REMOVE);
        w_ctrl.insert = w_commit && (r_op == OP_PUSH) && (r_hit || !w_full);
        w_ctrl.is_pop = (r_op == OP_POP);
        w_ctrl.item   = r_item;
        n_count       = r_count;
        n_status      = ST_DONE;
        if (r_op == OP_PUSH) begin
            if (!r_hit) begin
                if (w_full) n_status = ST_FULL;
                else        n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) n_status = ST_EMPTY_POP;
            else         n_count  = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured item and match flag (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op         <= t_op'(i_operation);
            r_item.valid <= 1'b1;
            r_item.ident <= i_ident;
            r_item.key   <= i_prio_key;
        end
        if (r_state == S_REMOVE) begin
            r_hit <= w_shift[CAPACITY-1];
        end
    end

    // result: head cell as it will be after the insertion pass
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_min_ident <= w_next[0].valid ? w_next[0].ident : '0;
            r_min_key   <= w_next[0].valid ? w_next[0].key   : '0;
            r_is_empty  <= !w_next[0].valid;
            r_res_count <= n_count;
            r_status    <= n_status;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left, w_right;
            logic   w_left_shift, w_left_lt;
            if (g == 0) begin : g_head
                assign w_left       = '0;
                // pop removes the head: start the shift at the first cell
                assign w_left_shift = w_ctrl.remove && w_ctrl.is_pop;
                assign w_left_lt    = 1'b0;
            end else begin : g_body
                assign w_left       = w_entry[g-1];
                assign w_left_shift = w_shift[g-1];
                assign w_left_lt    = w_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_mid
                assign w_right = w_entry[g+1];
            end
            idxpq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_left       (w_left),
                .i_right      (w_right),
                .i_left_shift (w_left_shift),
                .i_left_lt    (w_left_lt),
                .o_entry      (w_entry[g]),
                .o_next       (w_next[g]),
                .o_shift      (w_shift[g]),
                .o_lt         (w_lt[g])
            );
        end
    endgenerate

    assign w_count_ext   = EXT_W'(r_res_count);
    assign o_out_valid   = r_out_valid;
    assign o_min_ident   = r_min_ident;
    assign o_min_key     = r_min_key;
    assign o_is_empty    = r_is_empty;
    assign o_entry_count = w_count_ext[COUNT_OUT_W-1:0];
    assign o_status      = r_status;

endmodule

### test/tb_indexed_min_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_priority_queue - self-checking bench for the indexed min PQ
// Drives push/update/pop transfers with random idle and stall, mirrors the
// slot store in a shadow model and checks every result transfer against it.
// ----------------------------------------------------------------------------
module tb_indexed_min_priority_queue;

    import idxpq_pkg::*;

    localparam int SLOTS          = 16;
    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_ITEMS   = 530;
    localparam int IDLE_PCT       = 8;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // one result transfer, field by field
    typedef struct packed {
        logic [ID_W-1:0]         ident;
        logic signed [KEY_W-1:0] key;
        logic                    empty;
        logic [COUNT_OUT_W-1:0]  count;
        t_status                 status;
    } t_min_report;

    // ------------------------------------------------------------------------
    // Shadow copy of the slot store. apply_op() plays one accepted input and
    // queues the report it must produce; check_min_report() pops the oldest.
    // ------------------------------------------------------------------------
    class pq_shadow;
        bit                      used [SLOTS];
        logic [ID_W-1:0]         ids  [SLOTS];
        logic signed [KEY_W-1:0] keys [SLOTS];
        int                      held;
        t_min_report             owed_reports[$];
        int                      mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 1'b0;
                ids[i]  = '0;
                keys[i] = '0;
            end
            held       = 0;
            mismatches = 0;
        endfunction

        // slot of the smallest (key, ident), -1 when nothing held
        function int min_slot();
            int best;
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i]) begin
                    if (best < 0 || keys[i] < keys[best] ||
                        (keys[i] == keys[best] && ids[i] < ids[best])) begin
                        best = i;
                    end
                end
            end
            return best;
        endfunction

        function void apply_op(t_op op, logic [ID_W-1:0] ident,
                               logic signed [KEY_W-1:0] key);
            int          hit;
            int          free_slot;
            int          m;
            t_min_report rep;
            hit       = -1;
            free_slot = -1;
            rep       = '0;
            rep.status = ST_DONE;
            if (op == OP_PUSH) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (used[i]) begin
                        if (ids[i] == ident && hit < 0) hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    keys[hit] = key;              // key update, even when full
                end else if (free_slot >= 0) begin
                    used[free_slot] = 1'b1;
                    ids[free_slot]  = ident;
                    keys[free_slot] = key;
                    held++;
                end else begin
                    rep.status = ST_FULL;
                end
            end else begin
                m = min_slot();
                if (m >= 0) begin
                    used[m] = 1'b0;
                    ids[m]  = '0;
                    keys[m] = '0;
                    held--;
                end else begin
                    rep.status = ST_EMPTY_POP;
                end
            end
            m = min_slot();
            if (m >= 0) begin
                rep.ident = ids[m];
                rep.key   = keys[m];
                rep.empty = 1'b0;
            end else begin
                rep.empty = 1'b1;
            end
            rep.count = held[COUNT_OUT_W-1:0];
            owed_reports.push_back(rep);
        endfunction

        function void check_min_report(t_min_report got);
            t_min_report want;
            if (owed_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result transfer with nothing owed: ident=%0d key=%0d",
                             got.ident, got.key);
                return;
            end
            want = owed_reports.pop_front();
            if (got.ident !== want.ident || got.key !== want.key ||
                got.empty !== want.empty || got.count !== want.count ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: min report mismatch");
                    $display("  expected ident=%0d key=%0d empty=%0b count=%0d status=%0d",
                             want.ident, want.key, want.empty, want.count, want.status);
                    $display("  actual   ident=%0d key=%0d empty=%0b count=%0d status=%0d",
                             got.ident, got.key, got.empty, got.count, got.status);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_operation;
    logic [ID_W-1:0]         i_ident;
    logic signed [KEY_W-1:0] i_prio_key;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [ID_W-1:0]         o_min_ident;
    logic signed [KEY_W-1:0] o_min_key;
    logic                    o_is_empty;
    logic [COUNT_OUT_W-1:0]  o_entry_count;
    logic [1:0]              o_status;

    indexed_min_priority_queue #(
        .CAPACITY (SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_ident       (i_ident),
        .i_prio_key    (i_prio_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_min_ident   (o_min_ident),
        .o_min_key     (o_min_key),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    pq_shadow shadow;

    // calm: both sides stop idling for a stretch of the random part
    bit calm;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Result side. Sample at the edge (values from before the edge), then pick
    // the stall for the next cycle. One NBA to i_out_stall per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_min_report got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ident  = o_min_ident;
            got.key    = o_min_key;
            got.empty  = o_is_empty;
            got.count  = o_entry_count;
            got.status = t_status'(o_status);
            shadow.check_min_report(got);
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Input side. Called at a rising edge: maybe idle a few cycles, present
    // the item and hold it until the edge that takes the transfer. Valid is
    // only dropped for an idle cycle, never toggled within one edge.
    // ------------------------------------------------------------------------
    task automatic send_item(t_op op, logic [ID_W-1:0] ident,
                             logic signed [KEY_W-1:0] key);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_ident     <= ident;
        i_prio_key  <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.apply_op(op, ident, key);
    endtask

    // Random item. Idents mostly come from a small pool so updates hit held
    // entries and the store really fills; some use the full 16-bit range.
    // Keys mix a narrow band (lots of ties), full range and the extremes.
    task automatic random_item(int push_pct);
        t_op                     op;
        logic [31:0]             r;
        logic [ID_W-1:0]         ident;
        logic signed [KEY_W-1:0] key;
        int                      pick;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        r  = $urandom();
        if ($urandom_range(0, 99) < 85)
            ident = ID_W'($urandom_range(0, 23));
        else
            ident = r[ID_W-1:0];
        pick = $urandom_range(0, 9);
        r    = $urandom();
        if (pick < 4)
            key = KEY_W'($signed($urandom_range(0, 7)) - 4);
        else if (pick < 8)
            key = $signed(r);
        else if (pick == 8)
            key = r[0] ? KEY_MAX : KEY_MIN;
        else
            key = r[0] ? '1 : '0;
        send_item(op, ident, key);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        shadow = new();
        calm   = 1'b0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_PUSH;
        i_ident     <= '0;
        i_prio_key  <= '0;
        i_out_stall <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pop on empty, key/ident extremes, tie on key, key update,
        // fill to capacity, new ident into a full store, update while full
        send_item(OP_POP,  '0,         '0);
        send_item(OP_PUSH, 16'hFFFF,   KEY_MAX);
        send_item(OP_PUSH, 16'h0000,   KEY_MIN);
        send_item(OP_PUSH, 16'h0001,   KEY_MIN);   // same key, larger ident
        send_item(OP_PUSH, 16'h0000,   KEY_MAX);   // update, ident 1 now min
        send_item(OP_PUSH, 16'h5A5A,   -32'sd1);
        send_item(OP_POP,  16'hFFFF,   KEY_MAX);   // payload ignored on pop
        for (int j = 0; j < 13; j++)
            send_item(OP_PUSH, ID_W'(100 + j), KEY_W'(j - 6));
        send_item(OP_PUSH, 16'hA5A5,   KEY_MIN);   // full: dropped
        send_item(OP_PUSH, 16'hFFFF,   KEY_MIN);   // full but held: updated
        send_item(OP_POP,  '0,         '0);

        // random: alternate fill-heavy and drain-heavy phases so the store
        // keeps swinging between full and empty
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 220 && n < 340);
            random_item(((n / 40) % 2 == 0) ? 75 : 30);
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (shadow.owed_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.owed_reports.size() != 0)
            shadow.mismatches++;
        if (shadow.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hard stop if a handshake hangs
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

endmodule
